FILE: sv/ktmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad trie match counter package
// Shared sizes, opcode and status codes, the trie row layout, the command and
// status bundles between controller and datapath, and the keypad digit map.
// ----------------------------------------------------------------------------
package ktmc_pkg;

	// Sizing of the trie, the count table and the item fields.
	localparam int MAX_SYMBOLS   = 6;
	localparam int NODE_POOL     = 32768;
	localparam int PATTERN_SLOTS = 4096;
	localparam int FIELD_SYMBOLS = 6;
	localparam int SYM_W         = 5;
	localparam int FANOUT        = 10;
	localparam int DIGIT_W       = 4;
	localparam int LEN_W         = 3;
	localparam int IDX_W         = 12;
	localparam int COUNT_W       = 16;

	localparam int USE_SYMBOLS = (MAX_SYMBOLS < FIELD_SYMBOLS) ? MAX_SYMBOLS : FIELD_SYMBOLS;
	localparam int NODE_W      = $clog2(NODE_POOL);
	localparam int NU_W        = NODE_W + 1;
	localparam int CNT_AW      = $clog2(PATTERN_SLOTS);

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [DIGIT_W-1:0] MAX_DIGIT = 4'd9;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_QUERY  = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POOL_FULL = 2'd1,
		ST_NO_MATCH  = 2'd2
	} status_t;

	// One trie node: its tag and its ten child links (zero means no child).
	typedef struct packed {
		logic                         tag_valid;
		logic [IDX_W-1:0]             tag;
		logic [FANOUT-1:0][NODE_W-1:0] links;
	} row_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    capture;
		logic    rd_root;
		logic    follow;
		logic    wr_link;
		logic    alloc;
		logic    wr_tag;
		logic    rd_cnt_idx;
		logic    rd_cnt_tag;
		logic    wr_cnt_inc;
		logic    sweep_start;
		logic    sweep_step;
		logic    clr_root;
		logic    out_load;
		logic    out_use_cnt;
		status_t out_status;
	} ktmc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic len_zero;
		logic ins_bad;
		logic idx_bad;
		logic at_end;
		logic link_zero;
		logic tag_valid;
		logic tag_in_range;
		logic pool_full;
		logic sweep_last;
	} ktmc_sts_t;

	// Phone keypad digit of a lowercase letter; codes past z map to key 0.
	function automatic logic [DIGIT_W-1:0] keypad_digit(input logic [SYM_W-1:0] sym);
		logic [DIGIT_W-1:0] d;
		case (sym) inside
			[5'd0:5'd2]:   d = 4'd2;
			[5'd3:5'd5]:   d = 4'd3;
			[5'd6:5'd8]:   d = 4'd4;
			[5'd9:5'd11]:  d = 4'd5;
			[5'd12:5'd14]: d = 4'd6;
			[5'd15:5'd18]: d = 4'd7;
			[5'd19:5'd21]: d = 4'd8;
			[5'd22:5'd25]: d = 4'd9;
			default:       d = 4'd0;
		endcase
		return d;
	endfunction

endpackage

FILE: sv/ktmc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad trie match counter datapath
// Holds the item registers, the trie node memory, the count memory, the walk
// pointer and the result registers, and acts on controller commands.
// ----------------------------------------------------------------------------
module ktmc_dp import ktmc_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [1:0]                   opcode,
	input  logic [LEN_W-1:0]             length,
	input  logic [FIELD_SYMBOLS*SYM_W-1:0] symbols,
	input  logic [IDX_W-1:0]             pattern_index,
	input  ktmc_cmd_t                    cmd,
	output ktmc_sts_t                    sts,
	output logic [1:0]                   status,
	output logic [COUNT_W-1:0]           count
);

	// Item registers.
	op_t                                   op_q;
	logic [LEN_W-1:0]                      len_q;
	logic [FIELD_SYMBOLS-1:0][SYM_W-1:0]   sym_q;
	logic [IDX_W-1:0]                      idx_q;

	// Walk state.
	logic [NODE_W-1:0] node_q;
	logic [LEN_W-1:0]  pos_q;
	logic [NU_W-1:0]   nodes_used_q;
	logic              root_valid_q;
	logic [CNT_AW-1:0] sweep_q;

	// Memories and their read registers.
	row_t               trie_mem [NODE_POOL];
	row_t               row_rd_q;
	logic               rd_root_zero_q;
	logic [COUNT_W-1:0] cnt_mem [PATTERN_SLOTS];
	logic [COUNT_W-1:0] cnt_rd_q;
	logic [CNT_AW-1:0]  cnt_addr_q;

	// Result registers.
	status_t            status_q;
	logic [COUNT_W-1:0] count_q;

	logic [SYM_W-1:0]   cur_sym;
	logic [DIGIT_W-1:0] digit;
	row_t               row_eff;
	logic [NODE_W-1:0]  link;
	logic [NODE_W-1:0]  fresh;
	logic               bad_digit;
	logic               row_we;
	logic [NODE_W-1:0]  row_waddr;
	row_t               row_wdata;
	logic               row_re;
	logic [NODE_W-1:0]  row_raddr;
	logic               cnt_re;
	logic [CNT_AW-1:0]  cnt_raddr;
	logic               cnt_we;
	logic [CNT_AW-1:0]  cnt_waddr;
	logic [COUNT_W-1:0] cnt_wdata;

	// Capture an accepted item, clamping the length to the usable symbols.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op_t'(opcode);
			len_q <= (length > LEN_W'(USE_SYMBOLS)) ? LEN_W'(USE_SYMBOLS) : length;
			sym_q <= symbols;
			idx_q <= pattern_index;
		end
	end

	// Symbol under the walk pointer and the branch digit it selects.
	always_comb begin
		cur_sym = (pos_q < LEN_W'(FIELD_SYMBOLS)) ? sym_q[pos_q] : '0;
		digit   = (op_q == OP_INSERT) ? cur_sym[DIGIT_W-1:0] : keypad_digit(cur_sym);
	end

	// An insert is dropped if any used symbol is not a decimal digit.
	always_comb begin
		bad_digit = 1'b0;
		for (int i = 0; i < FIELD_SYMBOLS; i++) begin
			if ((LEN_W'(i) < len_q) && (sym_q[i] > SYM_W'(MAX_DIGIT))) begin
				bad_digit = 1'b1;
			end
		end
	end

	// The root row reads as empty until it is written after a clear.
	assign row_eff = rd_root_zero_q ? '0 : row_rd_q;
	assign link    = row_eff.links[digit];
	assign fresh   = nodes_used_q[NODE_W-1:0];

	// Trie write port: new link in the parent, empty fresh node, or tag.
	always_comb begin
		row_we    = 1'b0;
		row_waddr = node_q;
		row_wdata = row_eff;
		if (cmd.wr_tag) begin
			row_we              = 1'b1;
			row_wdata.tag_valid = 1'b1;
			row_wdata.tag       = idx_q;
		end
		if (cmd.wr_link) begin
			row_we                 = 1'b1;
			row_wdata.links[digit] = fresh;
		end
		if (cmd.alloc) begin
			row_we    = 1'b1;
			row_waddr = fresh;
			row_wdata = '0;
		end
	end

	// Trie read port: the root at the start, then the child being followed.
	assign row_re    = cmd.rd_root | cmd.follow;
	assign row_raddr = cmd.rd_root ? '0 : link;

	// Trie node memory. A freshly allocated node is known to be empty.
	always_ff @(posedge clk) begin
		if (row_we) begin
			trie_mem[row_waddr] <= row_wdata;
		end
		if (row_re) begin
			row_rd_q       <= trie_mem[row_raddr];
			rd_root_zero_q <= (row_raddr == '0) && !root_valid_q;
		end else if (cmd.alloc) begin
			row_rd_q       <= '0;
			rd_root_zero_q <= 1'b0;
		end
	end

	// Walk pointer and symbol position.
	always_ff @(posedge clk) begin
		if (cmd.rd_root) begin
			node_q <= '0;
			pos_q  <= '0;
		end else if (cmd.follow) begin
			node_q <= link;
			pos_q  <= pos_q + 1'b1;
		end else if (cmd.alloc) begin
			node_q <= fresh;
			pos_q  <= pos_q + 1'b1;
		end
	end

	// Node pool fill, root validity and the count clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_used_q <= NU_W'(1);
			root_valid_q <= 1'b0;
			sweep_q      <= '0;
		end else begin
			if (cmd.clr_root) begin
				nodes_used_q <= NU_W'(1);
			end else if (cmd.alloc) begin
				nodes_used_q <= nodes_used_q + 1'b1;
			end
			if (cmd.clr_root) begin
				root_valid_q <= 1'b0;
			end else if (row_we && (row_waddr == '0)) begin
				root_valid_q <= 1'b1;
			end
			if (cmd.sweep_start) begin
				sweep_q <= '0;
			end else if (cmd.sweep_step) begin
				sweep_q <= sweep_q + 1'b1;
			end
		end
	end

	// Count memory ports: lookup by index or tag, saturating increment, sweep.
	always_comb begin
		cnt_re    = cmd.rd_cnt_idx | cmd.rd_cnt_tag;
		cnt_raddr = cmd.rd_cnt_tag ? row_eff.tag[CNT_AW-1:0] : idx_q[CNT_AW-1:0];
		cnt_we    = cmd.sweep_step | cmd.wr_cnt_inc;
		cnt_waddr = cmd.sweep_step ? sweep_q : cnt_addr_q;
		if (cmd.sweep_step) begin
			cnt_wdata = '0;
		end else if (cnt_rd_q == COUNT_MAX) begin
			cnt_wdata = cnt_rd_q;
		end else begin
			cnt_wdata = cnt_rd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (cnt_re) begin
			cnt_rd_q   <= cnt_mem[cnt_raddr];
			cnt_addr_q <= cnt_raddr;
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q <= cmd.out_status;
			count_q  <= cmd.out_use_cnt ? cnt_rd_q : '0;
		end
	end

	assign status = status_q;
	assign count  = count_q;

	// Status toward the controller.
	always_comb begin
		sts.op           = op_q;
		sts.len_zero     = (len_q == '0);
		sts.idx_bad      = ({1'b0, idx_q} >= (IDX_W+1)'(PATTERN_SLOTS));
		sts.ins_bad      = sts.len_zero | sts.idx_bad | bad_digit;
		sts.at_end       = (pos_q == len_q);
		sts.link_zero    = (link == '0);
		sts.tag_valid    = row_eff.tag_valid;
		sts.tag_in_range = ({1'b0, row_eff.tag} < (IDX_W+1)'(PATTERN_SLOTS));
		sts.pool_full    = (nodes_used_q >= NU_W'(NODE_POOL));
		sts.sweep_last   = (sweep_q == CNT_AW'(PATTERN_SLOTS - 1));
	end

endmodule

FILE: sv/ktmc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad trie match counter controller
// Sequences one item at a time through the datapath: trie walk with node
// allocation, count lookup and update, count clearing sweeps, result handoff.
// ----------------------------------------------------------------------------
module ktmc_ctrl import ktmc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  ktmc_sts_t sts,
	output ktmc_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_RSWEEP,
		S_IDLE,
		S_START,
		S_WALK,
		S_ALLOC,
		S_CNT,
		S_CSWEEP,
		S_DONE
	} state_t;

	state_t  state_q, state_d;
	logic    out_valid_q, out_valid_d;
	status_t res_status_q, res_status_d;
	logic    res_cnt_q, res_cnt_d;

	// Next state and commands.
	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		res_status_d = res_status_q;
		res_cnt_d    = res_cnt_q;
		out_valid_d  = out_valid_q && !out_ready;
		case (state_q)
			S_RSWEEP: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_START;
				end
			end
			S_START: begin
				res_status_d = ST_OK;
				res_cnt_d    = 1'b0;
				case (sts.op)
					OP_CLEAR: begin
						cmd.clr_root    = 1'b1;
						cmd.sweep_start = 1'b1;
						state_d         = S_CSWEEP;
					end
					OP_INSERT: begin
						if (sts.ins_bad) begin
							state_d = S_DONE;
						end else begin
							cmd.rd_root = 1'b1;
							state_d     = S_WALK;
						end
					end
					OP_QUERY: begin
						if (sts.len_zero) begin
							res_status_d = ST_NO_MATCH;
							state_d      = S_DONE;
						end else begin
							cmd.rd_root = 1'b1;
							state_d     = S_WALK;
						end
					end
					OP_READ: begin
						if (sts.idx_bad) begin
							state_d = S_DONE;
						end else begin
							cmd.rd_cnt_idx = 1'b1;
							state_d        = S_CNT;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_WALK: begin
				if (sts.op == OP_INSERT) begin
					if (sts.at_end) begin
						cmd.wr_tag = 1'b1;
						state_d    = S_DONE;
					end else if (!sts.link_zero) begin
						cmd.follow = 1'b1;
					end else if (sts.pool_full) begin
						res_status_d = ST_POOL_FULL;
						state_d      = S_DONE;
					end else begin
						cmd.wr_link = 1'b1;
						state_d     = S_ALLOC;
					end
				end else begin
					if (sts.at_end) begin
						if (!sts.tag_valid) begin
							res_status_d = ST_NO_MATCH;
							state_d      = S_DONE;
						end else if (sts.tag_in_range) begin
							cmd.rd_cnt_tag = 1'b1;
							state_d        = S_CNT;
						end else begin
							state_d = S_DONE;
						end
					end else if (sts.link_zero) begin
						res_status_d = ST_NO_MATCH;
						state_d      = S_DONE;
					end else begin
						cmd.follow = 1'b1;
					end
				end
			end
			S_ALLOC: begin
				cmd.alloc = 1'b1;
				state_d   = S_WALK;
			end
			S_CNT: begin
				if (sts.op == OP_QUERY) begin
					cmd.wr_cnt_inc = 1'b1;
				end else begin
					res_cnt_d = 1'b1;
				end
				state_d = S_DONE;
			end
			S_CSWEEP: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// Hand the result over once the output register is free.
				if (!out_valid_q || out_ready) begin
					cmd.out_load    = 1'b1;
					cmd.out_status  = res_status_q;
					cmd.out_use_cnt = res_cnt_q;
					out_valid_d     = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_RSWEEP;
			out_valid_q  <= 1'b0;
			res_status_q <= ST_OK;
			res_cnt_q    <= 1'b0;
		end else begin
			state_q      <= state_d;
			out_valid_q  <= out_valid_d;
			res_status_q <= res_status_d;
			res_cnt_q    <= res_cnt_d;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: sv/keypad_trie_match_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad trie match counter
// Digit-pattern trie with per-pattern match counts for keypad-mapped words.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on in_valid/in_ready with opcode, length, symbols and
// pattern_index; each item yields exactly one result on out_valid/out_ready
// carrying status and count. One item is processed at a time; the next item
// is taken while an earlier result still waits in the output register.
// The trie walk steps through the node memory one symbol at a time:
//   insert: the walk, allocating a node for each missing link, then the
//           tag write; no walk when it is dropped at the start;
//   query:  the walk, then a count read-modify-write on a tagged match,
//           with an early end on a miss;  read: one count lookup;
//   clear:  the count clearing sweep.
// A clear runs a sweep over the count memory, one entry per cycle.
// After reset the same sweep runs with in_ready low; the trie then holds
// only an empty root. When the receiver stalls, the result holds in the
// output register and one further item may be accepted and processed up
// to its handoff.
// ----------------------------------------------------------------------------
module keypad_trie_match_counter import ktmc_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     opcode,
	input  logic [LEN_W-1:0]               length,
	input  logic [FIELD_SYMBOLS*SYM_W-1:0] symbols,
	input  logic [IDX_W-1:0]               pattern_index,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     status,
	output logic [COUNT_W-1:0]             count
);

	ktmc_cmd_t cmd;
	ktmc_sts_t sts;

	// Sequencer.
	ktmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Trie, counts and result registers.
	ktmc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.opcode        (opcode),
		.length        (length),
		.symbols       (symbols),
		.pattern_index (pattern_index),
		.cmd           (cmd),
		.sts           (sts),
		.status        (status),
		.count         (count)
	);

endmodule

FILE: sim/keypad_trie_match_counter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad trie match counter testbench
// Drives digit-pattern inserts, keypad-word queries, count reads and clears
// through the valid/ready item channels. A predictor in this file keeps its
// own trie, tags and counts. It works out the status and count of every
// accepted item, and the scoreboard checks each returned result in order.
// The run has a short directed table, then a long random mix with idle gaps
// on both sides, a long sink hold-off and pauses that drain the block.
// ----------------------------------------------------------------------------
module keypad_trie_match_counter_test;
	import ktmc_pkg::*;

	localparam int SYMS_W         = FIELD_SYMBOLS * SYM_W;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TAIL_CYCLES    = 64;
	localparam int HOLD_CYCLES    = 300;
	localparam int MAX_REPORTS    = 10;
	localparam int RANDOM_BLOCKS  = 16;
	localparam int BLOCK_ITEMS    = 100;
	localparam int KNOWN_MAX      = 256;

	// One returned result, with the opcode that caused it for reports.
	typedef struct {
		op_t                op;
		status_t            status;
		logic [COUNT_W-1:0] count;
	} outcome_t;

	// A result typed into the directed table, or none.
	typedef struct {
		bit                 fixed;
		status_t            status;
		logic [COUNT_W-1:0] count;
	} typed_result_t;

	// One row of the directed stimulus table.
	typedef struct {
		op_t                op;
		logic [LEN_W-1:0]   len;
		logic [SYMS_W-1:0]  syms;
		logic [IDX_W-1:0]   idx;
		bit                 fixed;
		status_t            status;
		logic [COUNT_W-1:0] count;
	} stim_row_t;

	// A digit pattern that was offered for insertion.
	typedef struct {
		logic [LEN_W-1:0]  len;
		logic [SYMS_W-1:0] digits;
	} pattern_t;

	logic               clk;
	logic               arst_n        = 1'b0;
	logic               in_valid      = 1'b0;
	logic               in_ready;
	logic [1:0]         opcode        = '0;
	logic [LEN_W-1:0]   length        = '0;
	logic [SYMS_W-1:0]  symbols       = '0;
	logic [IDX_W-1:0]   pattern_index = '0;
	logic               out_valid;
	logic               out_ready     = 1'b0;
	logic [1:0]         status;
	logic [COUNT_W-1:0] count;

	// Predictor state: trie links, node tags (valid bit on top) and counts.
	bit [NODE_W-1:0]  trie_link [NODE_POOL*FANOUT];
	bit [IDX_W:0]     node_label [NODE_POOL];
	bit [COUNT_W-1:0] tag_hits [PATTERN_SLOTS];
	int               trie_nodes_used = 1;

	outcome_t      awaited_results[$];
	typed_result_t typed_results[$];
	stim_row_t     directed_rows[$];
	pattern_t      known_patterns[$];

	int failures     = 0;
	int quiet_cycles = 0;
	int sink_hold    = 0;
	bit source_gaps  = 1'b0;
	bit sink_stalls  = 1'b0;

	keypad_trie_match_counter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.length       (length),
		.symbols      (symbols),
		.pattern_index(pattern_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.count        (count)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Key of a letter on a phone keypad; codes past z fall on key 0.
	function automatic int key_of_letter(input logic [SYM_W-1:0] letter);
		if (letter > 5'd25)
			return 0;
		if (letter < 5'd15)
			return 2 + letter / 3;
		if (letter < 5'd19)
			return 7;
		if (letter < 5'd22)
			return 8;
		return 9;
	endfunction

	// Some letter on the given key; keys 0 and 1 have none, so an unused code.
	function automatic logic [SYM_W-1:0] letter_on_key(input logic [SYM_W-1:0] digit);
		case (digit)
			5'd2: return SYM_W'($urandom_range(0, 2));
			5'd3: return SYM_W'($urandom_range(3, 5));
			5'd4: return SYM_W'($urandom_range(6, 8));
			5'd5: return SYM_W'($urandom_range(9, 11));
			5'd6: return SYM_W'($urandom_range(12, 14));
			5'd7: return SYM_W'($urandom_range(15, 18));
			5'd8: return SYM_W'($urandom_range(19, 21));
			5'd9: return SYM_W'($urandom_range(22, 25));
			default: return SYM_W'($urandom_range(26, 31));
		endcase
	endfunction

	// Packs six symbols, the first in the low bits.
	function automatic logic [SYMS_W-1:0] pack_symbols(input int s0, s1, s2, s3, s4, s5);
		return {SYM_W'(s5), SYM_W'(s4), SYM_W'(s3), SYM_W'(s2), SYM_W'(s1), SYM_W'(s0)};
	endfunction

	// Applies one item to the predictor state and returns its result.
	function automatic outcome_t trie_step(input op_t op, input logic [LEN_W-1:0] len_f,
			input logic [SYMS_W-1:0] syms, input logic [IDX_W-1:0] idx);
		outcome_t res;
		int       n;
		int       node;
		int       slot;
		int       fresh;
		bit       halt;
		res.op     = op;
		res.status = ST_OK;
		res.count  = '0;
		n = int'(len_f);
		if (n > MAX_SYMBOLS)
			n = MAX_SYMBOLS;
		if (n > FIELD_SYMBOLS)
			n = FIELD_SYMBOLS;
		case (op)
			OP_CLEAR: begin
				for (int i = 0; i < PATTERN_SLOTS; i++)
					tag_hits[i] = '0;
				for (int i = 0; i < FANOUT; i++)
					trie_link[i] = '0;
				trie_nodes_used = 1;
			end
			OP_INSERT: begin
				// Empty strings, bad digits and bad indexes leave the trie alone.
				halt = (n == 0) || (int'(idx) >= PATTERN_SLOTS);
				for (int i = 0; i < n; i++)
					if (syms[SYM_W*i +: SYM_W] > SYM_W'(MAX_DIGIT))
						halt = 1'b1;
				node = 0;
				for (int i = 0; i < n && !halt; i++) begin
					slot = node * FANOUT + int'(syms[SYM_W*i +: SYM_W]);
					if (trie_link[slot] == '0) begin
						if (trie_nodes_used >= NODE_POOL) begin
							// Nodes allocated so far stay, untagged.
							res.status = ST_POOL_FULL;
							halt = 1'b1;
						end else begin
							fresh = trie_nodes_used;
							for (int k = 0; k < FANOUT; k++)
								trie_link[fresh*FANOUT + k] = '0;
							node_label[fresh] = '0;
							trie_link[slot] = NODE_W'(fresh);
							trie_nodes_used++;
						end
					end
					if (!halt)
						node = int'(trie_link[slot]);
				end
				if (!halt)
					node_label[node] = {1'b1, idx};
			end
			OP_QUERY: begin
				halt = (n == 0);
				node = 0;
				for (int i = 0; i < n && !halt; i++) begin
					node = int'(trie_link[node*FANOUT + key_of_letter(syms[SYM_W*i +: SYM_W])]);
					if (node == 0)
						halt = 1'b1;
				end
				if (!halt && !node_label[node][IDX_W])
					halt = 1'b1;
				if (halt)
					res.status = ST_NO_MATCH;
				else if (tag_hits[node_label[node][IDX_W-1:0]] != COUNT_MAX)
					tag_hits[node_label[node][IDX_W-1:0]]++;
			end
			default: begin
				if (int'(idx) < PATTERN_SLOTS)
					res.count = tag_hits[idx];
			end
		endcase
		return res;
	endfunction

	// Scoreboard: predict on each accepted item, check each accepted result.
	always @(posedge clk) begin : scoreboard
		typed_result_t typed;
		outcome_t      want;
		if (in_valid && in_ready) begin
			typed = typed_results.pop_front();
			want = trie_step(op_t'(opcode), length, symbols, pattern_index);
			if (typed.fixed) begin
				want.status = typed.status;
				want.count  = typed.count;
			end
			awaited_results.push_back(want);
		end
		if (out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("%0t: result with none awaited: status=%0d count=%0d",
						$realtime, status, count);
			end else begin
				want = awaited_results.pop_front();
				if (status !== want.status || count !== want.count) begin
					failures++;
					if (failures <= MAX_REPORTS)
						$display("%0t: %s mismatch: expected status=%0d count=%0d, got status=%0d count=%0d",
							$realtime, want.op.name(), want.status, want.count, status, count);
				end
			end
		end
	end

	// Watchdog on cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Result sink: random stalls, plus a long hold-off when requested.
	initial begin : result_sink
		int stall_left;
		int r;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				stall_left = sink_hold;
				sink_hold = 0;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!sink_stalls) begin
				out_ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					stall_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(9, 59);
				end
			end
		end
	end

	// Idle cycles after an item: mostly none or short, now and then long.
	function automatic int source_gap();
		int r;
		if (!source_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offers one item and holds it until it is taken.
	task automatic offer(input op_t op, input logic [LEN_W-1:0] len,
			input logic [SYMS_W-1:0] syms, input logic [IDX_W-1:0] idx,
			input bit fixed, input status_t st, input logic [COUNT_W-1:0] cnt);
		typed_result_t typed;
		int            gap;
		typed.fixed  = fixed;
		typed.status = st;
		typed.count  = cnt;
		typed_results.push_back(typed);
		opcode        <= op;
		length        <= len;
		symbols       <= syms;
		pattern_index <= idx;
		in_valid      <= 1'b1;
		do @(posedge clk); while (!in_ready);
		gap = source_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic offer_checked(input op_t op, input logic [LEN_W-1:0] len,
			input logic [SYMS_W-1:0] syms, input logic [IDX_W-1:0] idx);
		offer(op, len, syms, idx, 1'b0, ST_OK, '0);
	endtask

	// Stops sending until every awaited result has come back.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_row(input op_t op, input int len, input logic [SYMS_W-1:0] syms,
			input int idx, input bit fixed, input status_t st, input int cnt);
		stim_row_t row;
		row.op     = op;
		row.len    = LEN_W'(len);
		row.syms   = syms;
		row.idx    = IDX_W'(idx);
		row.fixed  = fixed;
		row.status = st;
		row.count  = COUNT_W'(cnt);
		directed_rows.push_back(row);
	endtask

	task automatic remember_pattern(input pattern_t p);
		if (known_patterns.size() < KNOWN_MAX)
			known_patterns.push_back(p);
		else
			known_patterns[$urandom_range(0, KNOWN_MAX - 1)] = p;
	endtask

	// One random item: mostly well-formed inserts, queries on known patterns
	// and reads of busy tags, with some clears and raw noise.
	task automatic random_item(input bit allow_clear);
		int                r;
		int                n;
		int                j;
		logic [SYMS_W-1:0] s;
		logic [IDX_W-1:0]  ix;
		pattern_t          p;
		r  = $urandom_range(0, 199);
		s  = SYMS_W'($urandom);
		ix = ($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 15)) : IDX_W'($urandom);
		if (r < 2 && allow_clear) begin
			offer_checked(OP_CLEAR, LEN_W'($urandom_range(0, 7)), s, IDX_W'($urandom));
			known_patterns.delete();
		end else if (r < 62) begin
			n = $urandom_range(1, MAX_SYMBOLS);
			for (int i = 0; i < FIELD_SYMBOLS; i++)
				if (i < n || r >= 60)
					s[SYM_W*i +: SYM_W] = SYM_W'($urandom_range(0, 9));
			j = $urandom_range(0, 99);
			if (j < 6) begin
				// One bad digit spoils the whole insert.
				j = $urandom_range(0, n - 1);
				s[SYM_W*j +: SYM_W] = SYM_W'($urandom_range(10, 31));
			end else if (j < 8) begin
				n = 0;
			end else begin
				// An overlong length is cut down to the six symbols held.
				if (r >= 60)
					n = 7;
				p.len    = LEN_W'((n > MAX_SYMBOLS) ? MAX_SYMBOLS : n);
				p.digits = s;
				remember_pattern(p);
			end
			offer_checked(OP_INSERT, LEN_W'(n), s, ix);
		end else if (r < 142) begin
			n = $urandom_range(0, 7);
			if (known_patterns.size() != 0 && $urandom_range(0, 3) != 0) begin
				p = known_patterns[$urandom_range(0, known_patterns.size() - 1)];
				n = int'(p.len);
				// Now and then only a prefix of the pattern.
				if ($urandom_range(0, 9) == 0)
					n = $urandom_range(1, n);
				for (int i = 0; i < n; i++)
					s[SYM_W*i +: SYM_W] = letter_on_key(p.digits[SYM_W*i +: SYM_W]);
			end
			offer_checked(OP_QUERY, LEN_W'(n), s, IDX_W'($urandom));
		end else if (r < 182) begin
			offer_checked(OP_READ, LEN_W'($urandom_range(0, 7)), s, ix);
		end else begin
			offer_checked(op_t'($urandom_range(1, 3)), LEN_W'($urandom_range(0, 7)), s,
				IDX_W'($urandom));
		end
	endtask

	// Main stimulus sequence.
	initial begin : stimulus
		stim_row_t row;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; letters are a=0 .. z=25.
		add_row(OP_READ,   1, '0,                           0,    1, ST_OK,       0);
		add_row(OP_READ,   1, '0,                           4095, 1, ST_OK,       0);
		add_row(OP_QUERY,  1, pack_symbols(0,0,0,0,0,0),    0,    1, ST_NO_MATCH, 0);
		add_row(OP_QUERY,  0, pack_symbols(0,0,0,0,0,0),    0,    1, ST_NO_MATCH, 0);
		add_row(OP_INSERT, 0, pack_symbols(2,0,0,0,0,0),    1,    1, ST_OK,       0);
		add_row(OP_INSERT, 1, pack_symbols(2,0,0,0,0,0),    0,    1, ST_OK,       0);
		add_row(OP_QUERY,  1, pack_symbols(0,0,0,0,0,0),    0,    1, ST_OK,       0);
		add_row(OP_READ,   1, '0,                           0,    1, ST_OK,       1);
		// A digit above nine: nothing is inserted, so "dd" finds nothing.
		add_row(OP_INSERT, 2, pack_symbols(3,15,0,0,0,0),   2,    1, ST_OK,       0);
		add_row(OP_QUERY,  2, pack_symbols(3,3,0,0,0,0),    0,    1, ST_NO_MATCH, 0);
		add_row(OP_INSERT, 6, pack_symbols(9,9,9,9,9,9),    4095, 1, ST_OK,       0);
		add_row(OP_QUERY,  7, pack_symbols(25,25,25,25,25,25), 0, 1, ST_OK,       0);
		add_row(OP_READ,   1, '0,                           4095, 1, ST_OK,       1);
		// The same pattern again takes the new tag.
		add_row(OP_INSERT, 6, pack_symbols(9,9,9,9,9,9),    5,    0, ST_OK,       0);
		add_row(OP_QUERY,  6, pack_symbols(22,23,24,25,22,23), 0, 0, ST_OK,       0);
		add_row(OP_READ,   1, '0,                           5,    1, ST_OK,       1);
		add_row(OP_READ,   1, '0,                           4095, 1, ST_OK,       1);
		// Codes past z land on key 0.
		add_row(OP_INSERT, 1, pack_symbols(0,0,0,0,0,0),    7,    0, ST_OK,       0);
		add_row(OP_QUERY,  1, pack_symbols(26,0,0,0,0,0),   0,    0, ST_OK,       0);
		add_row(OP_QUERY,  1, pack_symbols(31,31,31,31,31,31), 0, 0, ST_OK,       0);
		add_row(OP_READ,   1, '0,                           7,    1, ST_OK,       2);
		// An inner node of a longer pattern carries no tag.
		add_row(OP_QUERY,  1, pack_symbols(22,0,0,0,0,0),   0,    1, ST_NO_MATCH, 0);
		add_row(OP_INSERT, 2, pack_symbols(1,2,31,31,31,31), 100, 0, ST_OK,       0);
		add_row(OP_INSERT, 7, '1,                           4095, 1, ST_OK,       0);
		add_row(OP_CLEAR,  1, '0,                           0,    1, ST_OK,       0);
		add_row(OP_READ,   1, '0,                           7,    1, ST_OK,       0);
		add_row(OP_QUERY,  1, pack_symbols(0,0,0,0,0,0),    0,    1, ST_NO_MATCH, 0);
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			offer(row.op, row.len, row.syms, row.idx, row.fixed, row.status, row.count);
		end

		// Random mix in blocks, each with its own idling pattern.
		for (int b = 0; b < RANDOM_BLOCKS; b++) begin
			source_gaps = ($urandom_range(0, 3) != 0);
			sink_stalls = ($urandom_range(0, 3) != 0);
			if (b == 5) begin
				// Long sink hold-off while items keep coming, to back up the block.
				sink_hold = HOLD_CYCLES;
				source_gaps = 1'b0;
				repeat (16) random_item(1'b0);
			end
			if (b == 8 || b == 12)
				settle();
			repeat (BLOCK_ITEMS) random_item(1'b1);
		end

		// A last stretch of random items with idling on both sides.
		source_gaps = 1'b1;
		sink_stalls = 1'b1;
		repeat (40) random_item(1'b1);

		// Drain, let the block go quiet, and report.
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0) begin
			failures += awaited_results.size();
			$display("%0t: %0d results never came", $realtime, awaited_results.size());
		end
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: filelist.f
sv/ktmc_pkg.sv
sv/ktmc_dp.sv
sv/ktmc_ctrl.sv
sv/keypad_trie_match_counter.sv
sim/keypad_trie_match_counter_test.sv
